// ===== hdl/a2d_pkg.sv =====
// ----------------------------------------------------------------------------
// a2d_pkg: shared constants, types and tables
// widths, fixed-point constants, error rom and cell payload type
// ----------------------------------------------------------------------------
package a2d_pkg;

  localparam int FRAC_W   = 16;
  localparam int NUM_CELLS = FRAC_W + 2;        // quotient bits 16..0 plus one
  localparam int MAG_W    = 18;                 // |num| up to 32768, den up to 65536
  localparam int REM_W    = MAG_W + FRAC_W;     // |num| * 2^16 and shifted divisor
  localparam int Q_W      = 18;                 // quotient magnitude, <= 2^16
  localparam int ROM_SIZE = 360;

  localparam logic [16:0] C1_Q16 = 17'd51472;
  localparam logic [17:0] C2_Q16 = 18'd154416;
  localparam logic [8:0]  CENTER_DEG = 9'd180;
  localparam logic [5:0]  SCALE_DEG  = 6'd57;
  localparam logic [3:0]  OFFSET_DEG = 4'd5;

  // payload carried down the divider row
  typedef struct packed {
    logic [REM_W-1:0] rem;     // partial remainder
    logic [MAG_W-1:0] den;     // divisor
    logic [Q_W-1:0]   quo;     // quotient bits so far
    logic             neg;     // quotient sign
    logic             xneg;    // x < 0
    logic             yneg;    // y < 0
    logic             dzero;   // divisor zero
  } a2d_cell_t;

  function automatic logic [3:0] corr_rom(input logic [8:0] idx);
    logic [3:0] t [0:ROM_SIZE-1];
    t = '{
 4'd5,4'd4,4'd6,4'd5,4'd6,4'd7,4'd5,4'd7,4'd8,4'd8,4'd5,4'd8,4'd9,4'd9,4'd9,
 4'd5,4'd9,4'd10,4'd10,4'd10,4'd10,4'd10,4'd10,4'd10,4'd10,4'd10,4'd10,4'd10,4'd10,4'd10,
 4'd9,4'd9,4'd9,4'd9,4'd9,4'd9,4'd8,4'd8,4'd8,4'd8,4'd7,4'd7,4'd7,4'd7,4'd6,
 4'd6,4'd6,4'd5,4'd5,4'd5,4'd5,4'd4,4'd4,4'd4,4'd4,4'd3,4'd3,4'd3,4'd3,4'd3,
 4'd2,4'd2,4'd2,4'd2,4'd2,4'd2,4'd2,4'd2,4'd2,4'd2,4'd2,4'd2,4'd2,4'd2,4'd2,
 4'd2,4'd2,4'd2,4'd2,4'd2,4'd5,4'd2,4'd3,4'd3,4'd5,4'd3,4'd4,4'd4,4'd5,4'd4,
 4'd5,4'd5,4'd5,4'd6,4'd5,4'd6,4'd7,4'd5,4'd7,4'd8,4'd8,4'd8,4'd5,4'd8,4'd9,
 4'd9,4'd9,4'd9,4'd9,4'd9,4'd9,4'd9,4'd9,4'd9,4'd9,4'd9,4'd9,4'd9,4'd9,4'd9,
 4'd9,4'd9,4'd9,4'd8,4'd8,4'd8,4'd8,4'd8,4'd7,4'd7,4'd7,4'd7,4'd6,4'd6,4'd6,
 4'd5,4'd5,4'd5,4'd5,4'd4,4'd4,4'd4,4'd4,4'd3,4'd3,4'd3,4'd3,4'd2,4'd2,4'd2,
 4'd2,4'd2,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,
 4'd1,4'd5,4'd1,4'd2,4'd2,4'd2,4'd2,4'd5,4'd2,4'd3,4'd5,4'd3,4'd4,4'd4,4'd5,
 4'd4,4'd5,4'd5,4'd6,4'd6,4'd5,4'd6,4'd7,4'd5,4'd7,4'd8,4'd8,4'd8,4'd8,4'd5,
 4'd8,4'd9,4'd9,4'd9,4'd9,4'd9,4'd9,4'd9,4'd9,4'd9,4'd9,4'd9,4'd9,4'd9,4'd8,
 4'd8,4'd8,4'd8,4'd8,4'd8,4'd7,4'd7,4'd7,4'd7,4'd6,4'd6,4'd6,4'd6,4'd5,4'd5,
 4'd5,4'd5,4'd4,4'd4,4'd4,4'd3,4'd3,4'd3,4'd3,4'd2,4'd2,4'd2,4'd2,4'd2,4'd1,
 4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,
 4'd1,4'd1,4'd1,4'd5,4'd1,4'd2,4'd2,4'd2,4'd5,4'd2,4'd3,4'd5,4'd3,4'd4,4'd5,
 4'd4,4'd5,4'd5,4'd5,4'd6,4'd6,4'd5,4'd6,4'd7,4'd7,4'd5,4'd7,4'd8,4'd8,4'd8,
 4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,
 4'd8,4'd8,4'd7,4'd7,4'd7,4'd7,4'd7,4'd6,4'd6,4'd6,4'd6,4'd5,4'd5,4'd5,4'd5,
 4'd4,4'd4,4'd4,4'd3,4'd3,4'd3,4'd3,4'd2,4'd2,4'd2,4'd2,4'd1,4'd1,4'd1,4'd1,
 4'd1,4'd1,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,
 4'd5,4'd0,4'd1,4'd1,4'd1,4'd5,4'd1,4'd2,4'd2,4'd5,4'd2,4'd3,4'd5,4'd3,4'd5};
    if (idx < 9'(ROM_SIZE)) begin
      return t[idx];
    end
    return t[ROM_SIZE-1];
  endfunction

endpackage

// ===== hdl/a2d_div_cell.sv =====
// ----------------------------------------------------------------------------
// a2d_div_cell: one restoring division step
// resolves one quotient bit and hands the payload on
// ----------------------------------------------------------------------------
module a2d_div_cell import a2d_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic       vld_in,
  input  logic [4:0] shift,
  input  a2d_cell_t  d_in,
  output logic       vld_out,
  output a2d_cell_t  d_out
);

  logic       vld_r;
  a2d_cell_t  d_r;
  a2d_cell_t  d_nxt;
  logic [REM_W-1:0] dsh;
  logic [REM_W-1:0] rem_w;

  always_comb begin
    d_nxt = d_in;
    dsh   = {{FRAC_W{1'b0}}, d_in.den} << shift;
    rem_w = d_in.rem;
    d_nxt.quo = d_in.quo << 1;
    if (rem_w >= dsh) begin
      d_nxt.rem = rem_w - dsh;
      d_nxt.quo[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign vld_out = vld_r;
  assign d_out   = d_r;

endmodule

// ===== hdl/a2d_post.sv =====
// ----------------------------------------------------------------------------
// a2d_post: angle formation and correction
// two registered steps: angle in radians, then scaling to degrees, truncation and rom correction
// ----------------------------------------------------------------------------
module a2d_post import a2d_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic       vld_in,
  input  a2d_cell_t  d_in,
  output logic       vld_out,
  output logic [8:0] angle_deg
);

  logic signed [18:0] r_s;
  logic signed [35:0] ang_nxt;   // q32 angle, below 2^34
  logic signed [35:0] ang_r;
  logic               yneg_r;
  logic               v1_r;
  logic signed [42:0] sum;
  logic [8:0]         theta;
  logic [9:0]         res;
  logic               v2_r;
  logic [8:0]         out_r;

  always_comb begin
    logic signed [18:0] qs;
    logic signed [18:0] omr;
    logic signed [17:0] c1s;
    logic signed [35:0] rc1;
    qs  = $signed({1'b0, d_in.quo});
    c1s = $signed({1'b0, C1_Q16});
    r_s = d_in.dzero ? -19'sd65536 : (d_in.neg ? -qs : qs);
    omr = 19'sd65536 - r_s;
    rc1 = r_s * c1s;
    if (!d_in.xneg) begin
      ang_nxt = omr * c1s;
    end else begin
      ang_nxt = ($signed({18'd0, C2_Q16}) <<< 16) - rc1;
    end
  end

  always_comb begin
    logic signed [42:0] sc;
    logic signed [6:0]  s57;
    s57 = $signed({1'b0, SCALE_DEG});
    sc  = ang_r * s57;
    sum = ($signed({34'd0, CENTER_DEG}) <<< 32) + (yneg_r ? -sc : sc);
    if (sum < 0) begin
      theta = 9'd0;
    end else if (sum[42:32] >= 11'(ROM_SIZE)) begin
      theta = 9'(ROM_SIZE - 1);
    end else begin
      theta = sum[40:32];
    end
    res = 10'(theta) - 10'(corr_rom(theta)) + 10'(OFFSET_DEG);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= vld_in;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang_r  <= ang_nxt;
      yneg_r <= d_in.yneg;
      out_r  <= res[8:0];
    end
  end

  assign vld_out   = v2_r;
  assign angle_deg = out_r;

endmodule

// ===== hdl/atan2_degrees_with_correction_unit.sv =====
// ----------------------------------------------------------------------------
// atan2_degrees_with_correction_unit: four-quadrant angle in whole degrees
// rational arctangent over a divider row, then rom error correction
// ----------------------------------------------------------------------------
// one x,y pair is taken every cycle and its angle passes through one input
// register, 18 divider cells each resolving one quotient bit, and two post
// stages; the whole row moves as one and stalls only when the output beat
// is held, so the rate is one pair per cycle with the consumer ready. 180 is
// the positive x axis; both inputs zero give the angle of theta 269.
module atan2_degrees_with_correction_unit import a2d_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_x_comp,
  input  logic [15:0] in_y_comp,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [8:0]  out_angle_deg
);

  logic       en;
  logic       v0_r;
  a2d_cell_t  c0_r;
  a2d_cell_t  c0_nxt;
  logic       cv [0:NUM_CELLS];
  a2d_cell_t  cd [0:NUM_CELLS];

  // pipeline advances unless a result beat is stuck at the output
  assign en       = out_ready || !out_valid;
  assign in_ready = en;

  // operand set-up: magnitudes of numerator and divisor, quotient sign
  always_comb begin
    logic signed [17:0] x, y, ay, num, den;
    x = 18'($signed(in_x_comp));
    y = 18'($signed(in_y_comp));
    ay = y[17] ? -y : y;
    if (!x[17]) begin
      num = x - ay;
      den = x + ay;
    end else begin
      num = x + ay;
      den = ay - x;
    end
    // dividend is |num| scaled by 2^16
    c0_nxt.rem   = {(num[17] ? MAG_W'(-num) : MAG_W'(num)), {FRAC_W{1'b0}}};
    c0_nxt.den   = MAG_W'(den);
    c0_nxt.quo   = '0;
    c0_nxt.neg   = num[17];
    c0_nxt.xneg  = x[17];
    c0_nxt.yneg  = y[17];
    c0_nxt.dzero = (den == 18'sd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c0_r <= c0_nxt;
    end
  end

  assign cv[0] = v0_r;
  assign cd[0] = c0_r;

  // divider row: cell k tries den << (17-k)
  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    a2d_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .vld_in  (cv[k]),
      .shift   (5'(NUM_CELLS - 1 - k)),
      .d_in    (cd[k]),
      .vld_out (cv[k+1]),
      .d_out   (cd[k+1])
    );
  end

  a2d_post u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .vld_in    (cv[NUM_CELLS]),
    .d_in      (cd[NUM_CELLS]),
    .vld_out   (out_valid),
    .angle_deg (out_angle_deg)
  );

endmodule

// ===== hdl/a2d_checker.sv =====
// ----------------------------------------------------------------------------
// a2d_checker: port-level checks
// result range and stall behaviour of the output beat
// ----------------------------------------------------------------------------
module a2d_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [8:0] out_angle_deg
);

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_angle_deg <= 9'd360) else $error("angle out of range");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_angle_deg))
    else $error("output beat dropped");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready) else $error("stalled with empty output");

endmodule

bind atan2_degrees_with_correction_unit a2d_checker u_a2d_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_angle_deg (out_angle_deg)
);
